// ===== rtl/core/rdft_pkg.sv =====
// Shared types, constants and twiddle functions for the real-input DFT accumulator.
package rdft_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int TW_W       = 16;
    localparam int PROD_W     = 32;
    localparam int ACC_W      = 37;
    localparam int BIN_W      = 5;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 80;
    localparam int POINTS_DEF = 32;

    // Twiddle ROM geometry: 64 phase steps, quarter wave of 17 entries
    localparam int PHASE_W   = 6;
    localparam int ROM_STEPS = 64;
    localparam logic [PHASE_W-1:0] SIN_SHIFT = 6'd48;

    localparam logic signed [TW_W-1:0] QUARTER_COS [17] = '{
        16'sd32767, 16'sd32609, 16'sd32137, 16'sd31356, 16'sd30273, 16'sd28898,
        16'sd27245, 16'sd25329, 16'sd23170, 16'sd20787, 16'sd18204, 16'sd15446,
        16'sd12539, 16'sd9512,  16'sd6393,  16'sd3212,  16'sd0
    };

    // Block control states
    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_FLUSH,
        ST_DRAIN
    } t_state;

    // Per-cycle control broadcast to every bin cell
    typedef struct packed {
        logic load;     // sample accepted: latch twiddles, advance index
        logic restart;  // accepted sample closes the block: index back to zero
        logic mul_en;   // product stage holds a valid sample
        logic acc_en;   // accumulate stage holds a valid product
        logic shift;    // move accumulators one cell toward the output
    } t_cell_ctl;

    // Cosine of ROM phase p, Q1.15
    function automatic logic signed [TW_W-1:0] f_cos(input logic [PHASE_W-1:0] p);
        logic [1:0]              q;
        logic [3:0]              r;
        logic [4:0]              rr;
        logic signed [TW_W-1:0]  v;
        q  = p[5:4];
        r  = p[3:0];
        rr = 5'd16 - {1'b0, r};
        unique case (q)
            2'd0: v = QUARTER_COS[r];
            2'd1: v = -QUARTER_COS[rr];
            2'd2: v = -QUARTER_COS[r];
            default: v = QUARTER_COS[rr];
        endcase
        return v;
    endfunction

    // Negated sine of ROM phase p, Q1.15
    function automatic logic signed [TW_W-1:0] f_neg_sin(input logic [PHASE_W-1:0] p);
        logic [PHASE_W-1:0] ps;
        ps = p + SIN_SHIFT;
        return -f_cos(ps);
    endfunction

endpackage

// ===== rtl/core/rdft_cell.sv =====
// One bin cell: twiddle index, two multipliers and the bin's real/imag accumulators.
module rdft_cell #(
    parameter int POINTS = rdft_pkg::POINTS_DEF,
    parameter int K      = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rdft_pkg::t_cell_ctl                i_ctl,
    input  logic signed [rdft_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [rdft_pkg::ACC_W-1:0]  i_next_re,
    input  logic signed [rdft_pkg::ACC_W-1:0]  i_next_im,
    output logic signed [rdft_pkg::ACC_W-1:0]  o_acc_re,
    output logic signed [rdft_pkg::ACC_W-1:0]  o_acc_im
);
    import rdft_pkg::*;

    localparam int KW = $clog2(POINTS);

    logic [KW-1:0]              r_m;
    logic [KW:0]                w_sum;
    logic [KW:0]                w_wrap;
    logic [PHASE_W-1:0]         w_tab [POINTS];
    logic [PHASE_W-1:0]         w_phase;
    logic signed [TW_W-1:0]     r_tw_re;
    logic signed [TW_W-1:0]     r_tw_im;
    logic signed [PROD_W-1:0]   r_prod_re;
    logic signed [PROD_W-1:0]   r_prod_im;
    logic signed [ACC_W-1:0]    r_acc_re;
    logic signed [ACC_W-1:0]    r_acc_im;

    // Map twiddle index to nearest ROM phase, built at elaboration
    for (genvar j = 0; j < POINTS; j++) begin : g_tab
        assign w_tab[j] = PHASE_W'((j * ROM_STEPS + POINTS / 2) / POINTS);
    end

    assign w_phase = w_tab[r_m];

    // Advance index by k modulo the block length
    assign w_sum  = {1'b0, r_m} + (KW+1)'(K);
    assign w_wrap = (w_sum >= (KW+1)'(POINTS)) ? (w_sum - (KW+1)'(POINTS)) : w_sum;

    // Hold the index of the next sample, latch twiddles on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= '0;
        end else if (i_ctl.load) begin
            r_m <= i_ctl.restart ? '0 : w_wrap[KW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_tw_re <= f_cos(w_phase);
            r_tw_im <= f_neg_sin(w_phase);
        end
    end

    // Register products
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod_re <= i_x * r_tw_re;
            r_prod_im <= i_x * r_tw_im;
        end
    end

    // Accumulate, or shift toward the output while draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (i_ctl.shift) begin
            r_acc_re <= i_next_re;
            r_acc_im <= i_next_im;
        end else if (i_ctl.acc_en) begin
            r_acc_re <= r_acc_re + ACC_W'(r_prod_re);
            r_acc_im <= r_acc_im + ACC_W'(r_prod_im);
        end
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

// ===== rtl/core/real_input_dft_accumulator.sv =====
// Top level of the real-input DFT accumulator: control, sample register and cell chain.
//
// Usage:
//   Slave stream (i_s_axis_*): one real 16-bit sample per word. Samples are taken
//   one per cycle while the block is accumulating; word n of a block is x[n].
//   Master stream (o_m_axis_*): after the POINTS-th sample, POINTS result words
//   follow, bin 0 first, tlast on the final bin. tuser carries the bin number.
// Timing:
//   Accumulation runs at one sample per cycle: every bin cell updates its
//   accumulators in parallel through a three-stage sample/product/sum pipeline.
//   After the last sample of a block, input ready drops, the pipeline empties
//   and the bins leave by shifting down the cell chain, one per cycle while the
//   receiver is ready. Input is not taken while results are being delivered.
// Reset and stall:
//   Synchronous active-low reset clears all accumulators, the sample position
//   and the pipeline. A receiver stall holds the current bin and the chain;
//   nothing is lost. Shifting in zeros leaves every cell cleared for the next block.
module real_input_dft_accumulator #(
    parameter int POINTS = rdft_pkg::POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tdata: [15:0] sample
    input  logic [rdft_pkg::TDATA_IN_W-1:0]      i_s_axis_tdata,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: [36:0] real_part, [73:37] imag_part, [79:74] zero
    output logic [rdft_pkg::TDATA_OUT_W-1:0]     o_m_axis_tdata,
    // tuser: [4:0] bin_index
    output logic [rdft_pkg::BIN_W-1:0]           o_m_axis_tuser,
    output logic                                 o_m_axis_tlast,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready
);
    import rdft_pkg::*;

    localparam int KW = $clog2(POINTS);

    t_state                     r_state;
    t_state                     n_state;
    logic [KW-1:0]              r_pos;
    logic [KW-1:0]              r_bin;
    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_v1;
    logic                       r_v2;
    logic                       w_in_acc;
    logic                       w_out_acc;
    logic                       w_pos_last;
    logic                       w_bin_last;
    t_cell_ctl                  w_ctl;
    logic signed [ACC_W-1:0]    w_re [POINTS+1];
    logic signed [ACC_W-1:0]    w_im [POINTS+1];

    assign w_in_acc   = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_acc  = o_m_axis_tvalid & i_m_axis_tready;
    assign w_pos_last = (r_pos == KW'(POINTS - 1));
    assign w_bin_last = (r_bin == KW'(POINTS - 1));

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshake outputs; hold input ready low during reset
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        unique case (r_state)
            ST_ACCUM: begin
                o_s_axis_tready = i_rst_n;
                if (i_s_axis_tvalid && w_pos_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_m_axis_tvalid = 1'b1;
                if (i_m_axis_tready && w_bin_last) begin
                    n_state = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    // Track sample position, output bin and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_bin <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            r_v1 <= w_in_acc;
            r_v2 <= r_v1;
            if (w_in_acc) begin
                r_pos <= w_pos_last ? '0 : r_pos + 1'b1;
            end
            if (w_out_acc) begin
                r_bin <= w_bin_last ? '0 : r_bin + 1'b1;
            end
        end
    end

    // Hold the accepted sample for the product stage
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x <= i_s_axis_tdata[SAMPLE_W-1:0];
        end
    end

    assign w_ctl.load    = w_in_acc;
    assign w_ctl.restart = w_pos_last;
    assign w_ctl.mul_en  = r_v1;
    assign w_ctl.acc_en  = r_v2;
    assign w_ctl.shift   = w_out_acc;

    // Chain of bin cells; zeros enter at the far end while draining
    assign w_re[POINTS] = '0;
    assign w_im[POINTS] = '0;

    for (genvar k = 0; k < POINTS; k++) begin : g_cell
        rdft_cell #(
            .POINTS (POINTS),
            .K      (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_x       (r_x),
            .i_next_re (w_re[k+1]),
            .i_next_im (w_im[k+1]),
            .o_acc_re  (w_re[k]),
            .o_acc_im  (w_im[k])
        );
    end

    // Result word from the head of the chain
    assign o_m_axis_tdata = {{(TDATA_OUT_W - 2*ACC_W){1'b0}}, w_im[0], w_re[0]};
    assign o_m_axis_tuser = BIN_W'(r_bin);
    assign o_m_axis_tlast = w_bin_last;

endmodule

// ===== rtl/core/rdft_chk.sv =====
// Port-level checker for the real-input DFT accumulator, bound to the top level.
module rdft_chk #(
    parameter int POINTS = rdft_pkg::POINTS_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_s_axis_tready,
    input logic [rdft_pkg::TDATA_OUT_W-1:0]   o_m_axis_tdata,
    input logic [rdft_pkg::BIN_W-1:0]         o_m_axis_tuser,
    input logic                               o_m_axis_tlast,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready
);
    import rdft_pkg::*;

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(POINTS - 1);

    // No sample is taken while results are offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready while results pending");

    // A result run starts at bin zero
    a_first_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> (o_m_axis_tuser == '0))
        else $error("result run does not start at bin zero");

    // Bins advance by one and tlast marks the final bin
    a_bin_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid && (o_m_axis_tuser == $past(o_m_axis_tuser) + 1'b1)))
        else $error("bin sequence broken");

    a_last_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |->
            (o_m_axis_tuser == LAST_BIN) ##1 !o_m_axis_tvalid)
        else $error("tlast on wrong bin or run continues");

    // Stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result word changed");

endmodule

bind real_input_dft_accumulator rdft_chk #(
    .POINTS (POINTS)
) u_rdft_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);
